FILE: src/fac_pkg.sv
// shared types, constants and the crc byte update for the frame address crc checker
package fac_pkg;

	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [23:0] ADDRESS_RESET = 24'h31FAB6;
	localparam logic [7:0]  MIN_FRAME_LEN = 8'd5;
	localparam logic [7:0]  COUNT_MAX     = 8'd255;
	localparam int          QUEUE_DEPTH   = 4;
	localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		STATUS_VALID     = 2'd0,
		STATUS_BAD_CRC   = 2'd1,
		STATUS_BAD_ADDR  = 2'd2,
		STATUS_TOO_SHORT = 2'd3
	} status_t;

	// one classified byte handed from the front to the back
	typedef struct packed {
		logic       crc_en;
		logic [7:0] crc_byte;
		logic       last;
		logic       too_short;
		logic       addr_bad;
		logic [15:0] rx_crc;
		logic [7:0] length;
	} fac_entry_t;

	// msb-first crc-16 update over one byte
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: src/frame_address_crc_checker.sv
// top level of the frame address crc checker
// Frame bytes enter one per transaction on the slave stream, the final byte
// marked by tlast. The first three bytes are compared with expected_address,
// a CRC-16 (poly 0x1021, seed 0xFFFF, msb first) runs over all but the last
// two bytes, and the last two bytes are the received crc. One result per
// frame leaves on the master stream after its final byte. A byte is taken
// every cycle while the four-entry queue between the classifying front end
// and the crc back end has room; a result passes the queue and then the
// output register after its last byte, and that single output register
// lets the back end keep draining the queue while a result waits, stalling
// only on a second frame end.
module frame_address_crc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,     // expected_address
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tlast,  // end_of_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [15:0] received_crc, [31:16] computed_crc,
	                                   // [39:32] frame_length
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	logic [23:0]          expected_address_q;
	fac_pkg::fac_entry_t  entry;
	fac_pkg::fac_entry_t  head;
	logic                 q_full;
	logic                 q_avail;
	logic                 q_pop;
	logic                 in_take;
	fac_pkg::status_t     res_status;
	logic [15:0]          res_rx_crc;
	logic [15:0]          res_calc_crc;
	logic [7:0]           res_length;

	// address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_address_q <= fac_pkg::ADDRESS_RESET;
		end else if (cfg_we) begin
			expected_address_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !q_full;
	assign in_take       = s_axis_tvalid && !q_full;

	fac_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_byte          (s_axis_tdata),
		.in_last          (s_axis_tlast),
		.in_take          (in_take),
		.expected_address (expected_address_q),
		.entry            (entry)
	);

	fac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_take),
		.push_entry (entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_avail),
		.head       (head)
	);

	fac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (q_avail),
		.head         (head),
		.pop          (q_pop),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_status   (res_status),
		.res_rx_crc   (res_rx_crc),
		.res_calc_crc (res_calc_crc),
		.res_length   (res_length)
	);

	// result packing
	assign m_axis_tdata = {res_length, res_calc_crc, res_rx_crc};
	assign m_axis_tuser = res_status;

endmodule

FILE: src/fac_front.sv
// front part: byte delay line, address collection, byte count and frame classification
module fac_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 in_take,
	input  logic [23:0]          expected_address,
	output fac_pkg::fac_entry_t  entry
);

	logic [15:0] held_q;
	logic [23:0] addr_q;
	logic [7:0]  count_q;
	logic [15:0] held_next;
	logic [23:0] addr_next;
	logic [7:0]  count_next;

	// next frame state for the byte on offer
	always_comb begin
		held_next  = {held_q[7:0], in_byte};
		addr_next  = (count_q < 8'd3) ? {addr_q[15:0], in_byte} : addr_q;
		count_next = (count_q < fac_pkg::COUNT_MAX) ? count_q + 8'd1 : count_q;
	end

	// entry for the back part
	always_comb begin
		entry.crc_en    = in_valid && (count_q >= 8'd2);
		entry.crc_byte  = held_q[15:8];
		entry.last      = in_last;
		entry.too_short = count_next < fac_pkg::MIN_FRAME_LEN;
		entry.addr_bad  = addr_next != expected_address;
		entry.rx_crc    = held_next;
		entry.length    = count_next;
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			addr_q  <= '0;
			count_q <= '0;
		end else if (in_take) begin
			if (in_last) begin
				held_q  <= '0;
				addr_q  <= '0;
				count_q <= '0;
			end else begin
				held_q  <= held_next;
				addr_q  <= addr_next;
				count_q <= count_next;
			end
		end
	end

endmodule

FILE: src/fac_queue.sv
// short fifo of classified bytes between the front and back parts
module fac_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fac_pkg::fac_entry_t  push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output fac_pkg::fac_entry_t  head
);

	fac_pkg::fac_entry_t          slot_q [fac_pkg::QUEUE_DEPTH];
	logic [fac_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [fac_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [fac_pkg::QPTR_W:0]     fill_q;

	assign full      = fill_q == (fac_pkg::QPTR_W+1)'(fac_pkg::QUEUE_DEPTH);
	assign not_empty = fill_q != '0;
	assign head      = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (fac_pkg::QPTR_W)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (fac_pkg::QPTR_W)'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (fac_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (fac_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: src/fac_back.sv
// back part: crc accumulation and the registered result
module fac_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	input  fac_pkg::fac_entry_t  head,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output fac_pkg::status_t     res_status,
	output logic [15:0]          res_rx_crc,
	output logic [15:0]          res_calc_crc,
	output logic [7:0]           res_length
);

	logic [15:0]       crc_q;
	logic [15:0]       crc_next;
	logic              out_valid_q;
	logic              slot_free;
	fac_pkg::status_t  status_next;

	assign slot_free = !out_valid_q || res_ready;
	assign pop       = avail && (!head.last || slot_free);
	assign res_valid = out_valid_q;

	// crc over the byte leaving the delay line
	always_comb begin
		crc_next = head.crc_en ? fac_pkg::crc_update(crc_q, head.crc_byte) : crc_q;
	end

	// frame verdict, too short first, then address, then crc
	always_comb begin
		priority if (head.too_short) begin
			status_next = fac_pkg::STATUS_TOO_SHORT;
		end else if (head.addr_bad) begin
			status_next = fac_pkg::STATUS_BAD_ADDR;
		end else if (crc_next != head.rx_crc) begin
			status_next = fac_pkg::STATUS_BAD_CRC;
		end else begin
			status_next = fac_pkg::STATUS_VALID;
		end
	end

	// accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= fac_pkg::CRC_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q <= head.last ? fac_pkg::CRC_SEED : crc_next;
			end
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			res_status   <= status_next;
			res_rx_crc   <= head.rx_crc;
			res_calc_crc <= crc_next;
			res_length   <= head.length;
		end
	end

endmodule

FILE: tb/sv/fac_tb_pkg.sv
// crc byte update shared by the frame checker and the frame builder of the testbench
`timescale 1ns / 100ps
package fac_tb_pkg;

	// bit-serial crc-16, msb of the byte first
	function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15] ^ data[i];
			r  = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ fac_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

FILE: tb/sv/fac_frame_checker.sv
// watches both streams of the frame checker, predicts each frame verdict and compares
`timescale 1ns / 100ps
module fac_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tlast,  // end_of_frame
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,  // [15:0] received_crc, [31:16] computed_crc,
	                                   // [39:32] frame_length
	input  logic [1:0]  m_axis_tuser,  // [1:0] status
	output int          mismatch_count,
	output int          results_pending
);

	typedef struct {
		fac_pkg::status_t status;
		logic [15:0]      rx_crc;
		logic [15:0]      calc_crc;
		logic [7:0]       length;
	} frame_verdict_t;

	frame_verdict_t verdict_queue [$];

	// own copy of the frame state and the address register
	logic [23:0] station_addr;
	logic [15:0] running_crc;
	logic [15:0] tail_bytes;
	logic [23:0] header_addr;
	logic [7:0]  frame_bytes_seen;

	// predict on accepted input, compare on accepted output
	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t v;
		frame_verdict_t got;
		if (!arst_n) begin
			station_addr     <= fac_pkg::ADDRESS_RESET;
			running_crc      <= fac_pkg::CRC_SEED;
			tail_bytes       <= '0;
			header_addr      <= '0;
			frame_bytes_seen <= '0;
			verdict_queue.delete();
			results_pending  <= 0;
		end else begin
			if (cfg_we) begin
				station_addr <= cfg_wdata;
			end

			// byte transaction: oldest held byte goes into the crc
			if (s_axis_tvalid && s_axis_tready) begin
				logic [15:0] c;
				logic [15:0] t;
				logic [23:0] a;
				logic [7:0]  n;
				c = running_crc;
				t = tail_bytes;
				a = header_addr;
				n = frame_bytes_seen;
				if (n >= 8'd2) begin
					c = fac_tb_pkg::crc16_ccitt_byte(c, t[15:8]);
				end
				t = {t[7:0], s_axis_tdata};
				if (n < 8'd3) begin
					a = {a[15:0], s_axis_tdata};
				end
				if (n != fac_pkg::COUNT_MAX) begin
					n = n + 8'd1;
				end
				if (s_axis_tlast) begin
					if (n < fac_pkg::MIN_FRAME_LEN) begin
						v.status = fac_pkg::STATUS_TOO_SHORT;
					end else if (a != station_addr) begin
						v.status = fac_pkg::STATUS_BAD_ADDR;
					end else if (c != t) begin
						v.status = fac_pkg::STATUS_BAD_CRC;
					end else begin
						v.status = fac_pkg::STATUS_VALID;
					end
					v.rx_crc   = t;
					v.calc_crc = c;
					v.length   = n;
					verdict_queue.push_back(v);
					c = fac_pkg::CRC_SEED;
					t = '0;
					a = '0;
					n = '0;
				end
				running_crc      <= c;
				tail_bytes       <= t;
				header_addr      <= a;
				frame_bytes_seen <= n;
			end

			// result transaction against the oldest verdict
			if (m_axis_tvalid && m_axis_tready) begin
				got.status   = fac_pkg::status_t'(m_axis_tuser);
				got.rx_crc   = m_axis_tdata[15:0];
				got.calc_crc = m_axis_tdata[31:16];
				got.length   = m_axis_tdata[39:32];
				if (verdict_queue.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected result: status %0d rx_crc %h calc_crc %h len %0d",
							got.status, got.rx_crc, got.calc_crc, got.length);
					end
					mismatch_count <= mismatch_count + 1;
				end else begin
					v = verdict_queue.pop_front();
					if (got.status !== v.status || got.rx_crc !== v.rx_crc ||
						got.calc_crc !== v.calc_crc || got.length !== v.length) begin
						if (mismatch_count < 10) begin
							$display("mismatch: expected status %0d rx_crc %h calc_crc %h len %0d",
								v.status, v.rx_crc, v.calc_crc, v.length);
							$display("          actual   status %0d rx_crc %h calc_crc %h len %0d",
								got.status, got.rx_crc, got.calc_crc, got.length);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			results_pending <= verdict_queue.size();
		end
	end

endmodule

FILE: tb/sv/frame_address_crc_checker_tb.sv
// stimulus and verdict for the frame address crc checker
`timescale 1ns / 100ps
module frame_address_crc_checker_tb;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_BAD_ADDR,
		FRAME_NOISE
	} frame_kind_t;

	localparam int PHASE_ITEMS = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] rx_byte
	logic        s_axis_tlast;  // end_of_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // [15:0] received_crc, [31:16] computed_crc,
	                            // [39:32] frame_length
	logic [1:0]  m_axis_tuser;  // [1:0] status

	int          mismatch_count;
	int          results_pending;

	logic [23:0] cur_addr;
	int          items_sent;
	bit          tx_idle_on;
	bit          rx_idle_on;
	bit          hold_req;

	frame_address_crc_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	fac_frame_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// result receiver: random back-pressure plus one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
		end
	end

	// one byte transaction, with an optional idle burst in front
	task automatic push_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// build a frame of the given length and kind, then send it
	task automatic send_frame(input int len, input frame_kind_t kind);
		logic [7:0]  fb [];
		logic [15:0] crc;
		logic [23:0] a;
		fb = new[len];
		for (int i = 0; i < len; i++) begin
			fb[i] = $urandom_range(0, 255);
		end
		if (kind != FRAME_NOISE && len >= int'(fac_pkg::MIN_FRAME_LEN)) begin
			a = cur_addr;
			if (kind == FRAME_BAD_ADDR) begin
				a = a ^ (24'h1 << $urandom_range(0, 23));
			end
			fb[0] = a[23:16];
			fb[1] = a[15:8];
			fb[2] = a[7:0];
			crc = fac_pkg::CRC_SEED;
			for (int i = 0; i < len - 2; i++) begin
				crc = fac_tb_pkg::crc16_ccitt_byte(crc, fb[i]);
			end
			if (kind == FRAME_BAD_CRC) begin
				crc = crc ^ 16'($urandom_range(1, 65535));
			end
			fb[len-2] = crc[15:8];
			fb[len-1] = crc[7:0];
		end
		for (int i = 0; i < len; i++) begin
			push_byte(fb[i], i == len - 1);
		end
	endtask

	// address write once the block has drained
	task automatic write_address(input logic [23:0] a);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= a;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_addr = a;
	endtask

	// main sequence
	initial begin
		logic [23:0] phase_addr [5];
		int          phase_end;
		int          pick;
		int          len;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cur_addr      = fac_pkg::ADDRESS_RESET;
		items_sent    = 0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		hold_req      = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: short frames, extreme bytes, each status at reset address
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		send_frame(3, FRAME_NOISE);
		send_frame(4, FRAME_NOISE);
		send_frame(5, FRAME_GOOD);
		send_frame(5, FRAME_BAD_CRC);
		send_frame(5, FRAME_BAD_ADDR);

		phase_addr[0] = 24'h000000;
		phase_addr[1] = 24'hFFFFFF;
		phase_addr[2] = 24'($urandom);
		phase_addr[3] = 24'($urandom);
		phase_addr[4] = 24'($urandom);

		// random phases, one address setting each
		for (int p = 0; p < 5; p++) begin
			write_address(phase_addr[p]);
			if (p == 0) begin
				hold_req = 1'b1;
			end
			if (p == 4) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			phase_end = items_sent + PHASE_ITEMS;
			if (p == 3) begin
				send_frame($urandom_range(256, 300), FRAME_GOOD);
				phase_end = items_sent + PHASE_ITEMS;
			end
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					len = $urandom_range(1, 4);
				end else begin
					len = $urandom_range(5, 20);
				end
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_frame(len, FRAME_GOOD);
				end else if (pick < 82) begin
					send_frame(len, FRAME_BAD_CRC);
				end else if (pick < 94) begin
					send_frame(len, FRAME_BAD_ADDR);
				end else begin
					send_frame(len, FRAME_NOISE);
				end
			end
		end

		// drain and verdict
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: frame_address_crc_checker.f
src/fac_pkg.sv
src/fac_front.sv
src/fac_queue.sv
src/fac_back.sv
src/frame_address_crc_checker.sv
tb/sv/fac_tb_pkg.sv
tb/sv/fac_frame_checker.sv
tb/sv/frame_address_crc_checker_tb.sv
